// ===== sv/rpt_pkg.sv =====
// Shared types and constants of the rigid point transform core.
package rpt_pkg;

   // Field widths
   localparam int COORD_WIDTH = 24;
   localparam int COEF_WIDTH  = 18;
   localparam int FRAC_BITS   = 16;
   localparam int ROW_WIDTH   = 3 * COEF_WIDTH;
   localparam int AXES        = 3;

   // Product, accumulator and rounded-sum widths
   localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
   localparam int ACC_WIDTH   = PROD_WIDTH + 3;
   localparam int RND_WIDTH   = ACC_WIDTH - FRAC_BITS;
   localparam int CSR_IDX_WIDTH = 3;

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_ROT_ROW_FIRST  = 3'd0,
      CSR_ROT_ROW_SECOND = 3'd1,
      CSR_ROT_ROW_THIRD  = 3'd2,
      CSR_SHIFT_X        = 3'd3,
      CSR_SHIFT_Y        = 3'd4,
      CSR_SHIFT_Z        = 3'd5
   } csr_index_type;

   // Reset loads the identity matrix: 1.0 on the diagonal
   localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << FRAC_BITS;
   localparam logic [ROW_WIDTH-1:0] ROW_FIRST_RESET  = {COEF_ONE, {(2*COEF_WIDTH){1'b0}}};
   localparam logic [ROW_WIDTH-1:0] ROW_SECOND_RESET =
      {{COEF_WIDTH{1'b0}}, COEF_ONE, {COEF_WIDTH{1'b0}}};
   localparam logic [ROW_WIDTH-1:0] ROW_THIRD_RESET  = {{(2*COEF_WIDTH){1'b0}}, COEF_ONE};

   // Round half up, then clamp to the coordinate range
   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) << (FRAC_BITS - 1);
   localparam logic signed [RND_WIDTH-1:0] COORD_MAX =
      RND_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [RND_WIDTH-1:0] COORD_MIN =
      RND_WIDTH'(-(64'sd1 <<< (COORD_WIDTH - 1)));

   // Point beat
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] px;
      logic signed [COORD_WIDTH-1:0] py;
      logic signed [COORD_WIDTH-1:0] pz;
      logic                          finite;
   } req_type;

   // Result beat
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] qx;
      logic signed [COORD_WIDTH-1:0] qy;
      logic signed [COORD_WIDTH-1:0] qz;
      logic                          untouched;
      logic                          clipped;
   } rsp_type;

endpackage

// ===== sv/rigid_point_transform_core.sv =====
// Rigid point transform core: q = R*p + t in fixed point, three register stages.
// Takes one point per clock and returns one result per point, in order, after
// it has passed through the multiply stage, the accumulate stage and the
// round/saturate output register. Stall ripples back through the stages, so
// bubbles are squeezed out and the input is only held off when every stage is
// full and the output is stalled. Coordinates are signed Q8.16, matrix
// coefficients signed Q2.16 packed m_r0|m_r1|m_r2 per row (m_r0 on top). Sums
// are exact, rounded half up to 16 fraction bits and clamped; clipped flags any
// clamped axis. A point with finite low passes through unchanged with untouched
// set. The user must change registers only while idle; the core does not check.
module rigid_point_transform_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rpt_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rpt_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [rpt_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [rpt_pkg::ROW_WIDTH-1:0]       csr_wdata
);
   import rpt_pkg::*;

   // Configuration registers
   logic [ROW_WIDTH-1:0]          rot_ff   [AXES];
   logic signed [COORD_WIDTH-1:0] shift_ff [AXES];

   // Stage valids and advance enables
   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   // Stage 1: products and the carried point
   logic signed [PROD_WIDTH-1:0]  prod_ff [AXES][AXES];
   logic signed [PROD_WIDTH-1:0]  prod_in [AXES][AXES];
   req_type                       pt1_ff;

   // Stage 2: accumulated sums
   logic signed [ACC_WIDTH-1:0]   acc_ff [AXES];
   logic signed [ACC_WIDTH-1:0]   acc_in [AXES];
   req_type                       pt2_ff;

   // Stage 3: output register
   rsp_type                       rsp_ff;
   rsp_type                       rsp_in;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]   <= ROW_FIRST_RESET;
         rot_ff[1]   <= ROW_SECOND_RESET;
         rot_ff[2]   <= ROW_THIRD_RESET;
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_ROW_FIRST:  rot_ff[0]   <= csr_wdata;
            CSR_ROT_ROW_SECOND: rot_ff[1]   <= csr_wdata;
            CSR_ROT_ROW_THIRD:  rot_ff[2]   <= csr_wdata;
            CSR_SHIFT_X:        shift_ff[0] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_SHIFT_Y:        shift_ff[1] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_SHIFT_Z:        shift_ff[2] <= csr_wdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Back pressure: a stage moves when it is empty or the next one moves
   assign adv3      = !v3_ff || !rsp_stall;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: nine coefficient-by-coordinate products
   always_comb begin
      logic signed [COORD_WIDTH-1:0] coord [AXES];
      logic signed [COEF_WIDTH-1:0]  cf;
      coord[0] = req_data.px;
      coord[1] = req_data.py;
      coord[2] = req_data.pz;
      for (int r = 0; r < AXES; r++) begin
         for (int c = 0; c < AXES; c++) begin
            cf = rot_ff[r][(AXES-c)*COEF_WIDTH-1 -: COEF_WIDTH];
            // Operands sign-extended to the full product width
            prod_in[r][c] = PROD_WIDTH'(cf) * PROD_WIDTH'(coord[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         prod_ff <= prod_in;
         pt1_ff  <= req_data;
      end
   end

   // Stage 2: sum products, translation and rounding half
   always_comb begin
      logic signed [COORD_WIDTH+FRAC_BITS-1:0] shift_term;
      for (int r = 0; r < AXES; r++) begin
         shift_term = {shift_ff[r], {FRAC_BITS{1'b0}}};
         acc_in[r] = ACC_WIDTH'(prod_ff[r][0]) + ACC_WIDTH'(prod_ff[r][1])
                   + ACC_WIDTH'(prod_ff[r][2]) + ACC_WIDTH'(shift_term) + ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         acc_ff <= acc_in;
         pt2_ff <= pt1_ff;
      end
   end

   // Stage 3: drop fraction, clamp, or pass the point through
   always_comb begin
      logic signed [RND_WIDTH-1:0]   rnd;
      logic signed [COORD_WIDTH-1:0] q [AXES];
      logic                          clip;
      clip = 1'b0;
      for (int r = 0; r < AXES; r++) begin
         rnd = acc_ff[r][ACC_WIDTH-1:FRAC_BITS];
         if (rnd > COORD_MAX) begin
            q[r] = COORD_MAX[COORD_WIDTH-1:0];
            clip = 1'b1;
         end else if (rnd < COORD_MIN) begin
            q[r] = COORD_MIN[COORD_WIDTH-1:0];
            clip = 1'b1;
         end else begin
            q[r] = rnd[COORD_WIDTH-1:0];
         end
      end
      if (pt2_ff.finite) begin
         rsp_in.qx        = q[0];
         rsp_in.qy        = q[1];
         rsp_in.qz        = q[2];
         rsp_in.untouched = 1'b0;
         rsp_in.clipped   = clip;
      end else begin
         rsp_in.qx        = pt2_ff.px;
         rsp_in.qy        = pt2_ff.py;
         rsp_in.qz        = pt2_ff.pz;
         rsp_in.untouched = 1'b1;
         rsp_in.clipped   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && v2_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // Pass-through and saturation never flag together
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.untouched && rsp_data.clipped))
      else $error("untouched and clipped both set");

   // Input is held off only when the output beat is stuck
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_stall))
      else $error("input stalled without full pipeline");

   // A held stage keeps its beat
   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !adv2) |=> v1_ff)
      else $error("stage 1 beat lost while stalled");

   // A beat leaving stage 2 into a free output shows up next cycle
   a_stage2_move: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && adv3) |=> v3_ff)
      else $error("stage 2 beat lost on advance");
`endif

endmodule
